// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked in every cycle, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dssp_pkg.sv =====
// Types, constants and helper functions of the dual speed segment packer.
package dssp_pkg;

   localparam int unsigned SPEED_W  = 14;
   localparam int unsigned REQ_W    = 32;
   localparam int unsigned RSP_W    = 80;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned DIGIT_W  = 4;

   localparam logic [SPEED_W-1:0] SPEED_MAX = 14'd9999;
   localparam logic [BYTE_W-1:0]  RPM_MARK  = 8'h80;
   localparam logic [BYTE_W-1:0]  PTR_FWD   = 8'h01;
   localparam logic [BYTE_W-1:0]  PTR_REV   = 8'h02;
   localparam logic [BYTE_W-1:0]  ICON_ON   = 8'h02;

   // Reciprocal multipliers for the decimal split (exact over the ranges used).
   localparam logic [13:0] RECIP_1000 = 14'd8389;  // >> 23
   localparam logic [5:0]  RECIP_100  = 6'd41;     // >> 12
   localparam logic [7:0]  RECIP_10   = 8'd205;    // >> 11

   typedef struct packed {
      logic set_blank;
      logic icon_hidden;
      logic reverse_dir;
   } flags_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] thou;
      logic [DIGIT_W-1:0] hund;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] ones;
   } digits_type;

   function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
      logic [BYTE_W-1:0] code;
      case (digit)
         4'd0:    code = 8'hFA;
         4'd1:    code = 8'h0A;
         4'd2:    code = 8'hD6;
         4'd3:    code = 8'h9E;
         4'd4:    code = 8'h2E;
         4'd5:    code = 8'hBC;
         4'd6:    code = 8'hFC;
         4'd7:    code = 8'h1A;
         4'd8:    code = 8'hFE;
         4'd9:    code = 8'hBE;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   function automatic logic [BYTE_W-1:0] first_byte(input logic [BYTE_W-1:0] act,
                                                    input logic [BYTE_W-1:0] set);
      return {set[7:4], act[7:4]};
   endfunction

   function automatic logic [BYTE_W-1:0] second_byte(input logic [BYTE_W-1:0] act,
                                                     input logic [BYTE_W-1:0] set);
      return {1'b0, set[3:0], 3'b000} | {4'b0000, act[3:1], 1'b0};
   endfunction

endpackage

// ===== rtl/core/dual_speed_segment_packer.sv =====
// Top level of the dual speed segment packer: five-stage display byte pipeline.
//
// The req channel takes one display update per transfer: a set speed and an
// actual speed (values above 9999 show as 9999) plus the blank, icon-hidden
// and direction flags. The rsp channel returns the ten LCD RAM bytes for
// that update, byte 18 in the lowest bits up to byte 36 in the highest.
//
// Five register stages: clamp, thousands split, hundreds split, tens and ones
// split, then segment lookup and byte packing into the output register.
// An accepted req transfer moves through the stage registers in order, and
// rsp_tvalid rises once it reaches the output register. Each split stage is
// one small reciprocal multiply and one constant multiply-subtract. One
// transfer is taken every clock while the receiver keeps up.
//
// Reset empties every stage; rsp_tvalid is low after it. When rsp_tready is
// low the output holds its result and stages behind it keep filling empty
// slots until the whole pipeline is full; then req_tready drops. No update
// is lost or repeated across a stall.
module dual_speed_segment_packer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // set_speed[13:0], actual_speed[27:14], set_blank[28], icon_hidden[29],
   // reverse_dir[30], zero pad[31]
   input  logic [dssp_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // ram_byte_18[7:0], ram_byte_20[15:8], ram_byte_22[23:16], ram_byte_24[31:24],
   // ram_byte_26[39:32], ram_byte_28[47:40], ram_byte_30[55:48],
   // ram_byte_32[63:56], ram_byte_34[71:64], ram_byte_36[79:72]
   output logic [dssp_pkg::RSP_W-1:0]   rsp_tdata
);
   import dssp_pkg::*;

   // Stage valid bits and stage advance enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // Stage 1: clamped speeds.
   logic [SPEED_W-1:0] set1_ff, act1_ff, set1_in, act1_in;
   flags_type          flg1_ff, flg1_in;
   // Stage 2: thousands digit and remainder below 1000.
   logic [DIGIT_W-1:0] set_th2_ff, act_th2_ff, set_th2_in, act_th2_in;
   logic [9:0]         set_r2_ff, act_r2_ff, set_r2_in, act_r2_in;
   flags_type          flg2_ff, flg2_in;
   // Stage 3: hundreds digit and remainder below 100.
   logic [DIGIT_W-1:0] set_th3_ff, act_th3_ff, set_hu3_ff, act_hu3_ff;
   logic [DIGIT_W-1:0] set_hu3_in, act_hu3_in;
   logic [6:0]         set_r3_ff, act_r3_ff, set_r3_in, act_r3_in;
   flags_type          flg3_ff;
   // Stage 4: all four digits.
   digits_type         set_d4_ff, act_d4_ff, set_d4_in, act_d4_in;
   flags_type          flg4_ff;
   // Stage 5: packed output bytes.
   logic [RSP_W-1:0]   out5_ff, out5_in;

   assign rdy5       = !v5_ff || rsp_tready;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign v1_in = req_tvalid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;
   assign v4_in = v3_ff;
   assign v5_in = v4_ff;

   // Stage 1: saturate both speeds.
   always_comb begin
      logic [SPEED_W-1:0] s_raw, a_raw;
      s_raw   = req_tdata[13:0];
      a_raw   = req_tdata[27:14];
      set1_in = (s_raw > SPEED_MAX) ? SPEED_MAX : s_raw;
      act1_in = (a_raw > SPEED_MAX) ? SPEED_MAX : a_raw;
      flg1_in = '{set_blank: req_tdata[28], icon_hidden: req_tdata[29],
                  reverse_dir: req_tdata[30]};
   end

   // Stage 2: thousands digit by reciprocal multiply.
   always_comb begin
      logic [27:0] s_prod, a_prod;
      logic [13:0] s_back, a_back;
      s_prod     = 28'(set1_ff) * 28'(RECIP_1000);
      a_prod     = 28'(act1_ff) * 28'(RECIP_1000);
      set_th2_in = s_prod[26:23];
      act_th2_in = a_prod[26:23];
      s_back     = 14'(set_th2_in) * 14'd1000;
      a_back     = 14'(act_th2_in) * 14'd1000;
      set_r2_in  = 10'(set1_ff - s_back);
      act_r2_in  = 10'(act1_ff - a_back);
      flg2_in    = flg1_ff;
   end

   // Stage 3: hundreds digit.
   always_comb begin
      logic [15:0] s_prod, a_prod;
      logic [9:0]  s_back, a_back;
      s_prod     = 16'(set_r2_ff) * 16'(RECIP_100);
      a_prod     = 16'(act_r2_ff) * 16'(RECIP_100);
      set_hu3_in = s_prod[15:12];
      act_hu3_in = a_prod[15:12];
      s_back     = 10'(set_hu3_in) * 10'd100;
      a_back     = 10'(act_hu3_in) * 10'd100;
      set_r3_in  = 7'(set_r2_ff - s_back);
      act_r3_in  = 7'(act_r2_ff - a_back);
   end

   // Stage 4: tens and ones digits.
   always_comb begin
      logic [14:0]        s_prod, a_prod;
      logic [DIGIT_W-1:0] s_tens, a_tens;
      logic [6:0]         s_back, a_back;
      s_prod = 15'(set_r3_ff) * 15'(RECIP_10);
      a_prod = 15'(act_r3_ff) * 15'(RECIP_10);
      s_tens = s_prod[14:11];
      a_tens = a_prod[14:11];
      s_back = 7'(s_tens) * 7'd10;
      a_back = 7'(a_tens) * 7'd10;
      set_d4_in = '{thou: set_th3_ff, hund: set_hu3_ff, tens: s_tens,
                    ones: 4'(set_r3_ff - s_back)};
      act_d4_in = '{thou: act_th3_ff, hund: act_hu3_ff, tens: a_tens,
                    ones: 4'(act_r3_ff - a_back)};
   end

   // Stage 5: segment lookup and packing into the LCD RAM byte order.
   always_comb begin
      logic [BYTE_W-1:0] s_th, s_hu, s_te, s_on;
      logic [BYTE_W-1:0] a_th, a_hu, a_te, a_on;
      logic [BYTE_W-1:0] ptr, icon;
      a_th = seg_code(act_d4_ff.thou);
      a_hu = seg_code(act_d4_ff.hund);
      a_te = seg_code(act_d4_ff.tens);
      a_on = seg_code(act_d4_ff.ones);
      // A blanked set row shows no segments at all.
      s_th = flg4_ff.set_blank ? '0 : seg_code(set_d4_ff.thou);
      s_hu = flg4_ff.set_blank ? '0 : seg_code(set_d4_ff.hund);
      s_te = flg4_ff.set_blank ? '0 : seg_code(set_d4_ff.tens);
      s_on = flg4_ff.set_blank ? '0 : seg_code(set_d4_ff.ones);
      ptr  = flg4_ff.icon_hidden ? '0 : (flg4_ff.reverse_dir ? PTR_REV : PTR_FWD);
      icon = flg4_ff.icon_hidden ? '0 : ICON_ON;
      out5_in = {first_byte(a_th, s_th),
                 second_byte(a_th, s_th),
                 second_byte(a_on, s_on),
                 first_byte(a_on, s_on),
                 second_byte(a_te, s_te) | RPM_MARK,
                 first_byte(a_te, s_te),
                 second_byte(a_hu, s_hu),
                 first_byte(a_hu, s_hu),
                 icon,
                 ptr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= v1_in;
         if (rdy2) v2_ff <= v2_in;
         if (rdy3) v3_ff <= v3_in;
         if (rdy4) v4_ff <= v4_in;
         if (rdy5) v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         set1_ff <= set1_in;
         act1_ff <= act1_in;
         flg1_ff <= flg1_in;
      end
      if (rdy2) begin
         set_th2_ff <= set_th2_in;
         act_th2_ff <= act_th2_in;
         set_r2_ff  <= set_r2_in;
         act_r2_ff  <= act_r2_in;
         flg2_ff    <= flg2_in;
      end
      if (rdy3) begin
         set_th3_ff <= set_th2_ff;
         act_th3_ff <= act_th2_ff;
         set_hu3_ff <= set_hu3_in;
         act_hu3_ff <= act_hu3_in;
         set_r3_ff  <= set_r3_in;
         act_r3_ff  <= act_r3_in;
         flg3_ff    <= flg2_ff;
      end
      if (rdy4) begin
         set_d4_ff <= set_d4_in;
         act_d4_ff <= act_d4_in;
         flg4_ff   <= flg3_ff;
      end
      if (rdy5) begin
         out5_ff <= out5_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = out5_ff;

endmodule

// ===== rtl/core/dssp_checker.sv =====
// Port-level checker for the dual speed segment packer, bound to the top level.
`include "assert_macros.svh"

module dssp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [dssp_pkg::RSP_W-1:0] rsp_tdata
);
   import dssp_pkg::*;

   logic ptr_shown;
   logic icon_shown;
   logic icon_clean;

   assign ptr_shown  = (rsp_tdata[7:0] != 8'h00);
   assign icon_shown = (rsp_tdata[15:8] != 8'h00);
   assign icon_clean = ((rsp_tdata[15:8] & 8'hFD) == 8'h00);

   // A stalled result stays offered.
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped")

   // Nothing comes out in the cycle after reset.
   `ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")

   // Every result carries the rpm mark.
   `ASSERT_RST(a_rpm_mark, clock, reset, rsp_tvalid |-> rsp_tdata[47], "rpm mark missing")

   // Pointer and icon are shown or hidden together, and the icon byte is bit1 only.
   `ASSERT_RST(a_icon_ptr, clock, reset, rsp_tvalid |-> (ptr_shown == icon_shown) && icon_clean, "icon")

endmodule

bind dual_speed_segment_packer dssp_checker u_dssp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
